[rtl/lexicographic_fifo_tiebreak_pqueue_top_macros.svh]
// ----------------------------------------------------------------------------
// lexicographic_fifo_tiebreak_pqueue_top_macros
// Assertion macros shared by the priority queue RTL; all sample on clk and
// are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LEXICOGRAPHIC_FIFO_TIEBREAK_PQUEUE_TOP_MACROS_SVH
`define LEXICOGRAPHIC_FIFO_TIEBREAK_PQUEUE_TOP_MACROS_SVH

// same-cycle implication
`define LFPQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LFPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/lfpq_pkg.sv]
// ----------------------------------------------------------------------------
// lfpq_pkg
// Shared constants, operation and status codes, and the cell control bundle
// of the lexicographic priority queue.
// ----------------------------------------------------------------------------
package lfpq_pkg;

	// default sizes
	localparam int CAPACITY     = 64;
	localparam int MAX_COSTS    = 4;
	localparam int COST_BITS    = 16;
	localparam int ID_BITS      = 24;
	// cost fields carried on the stream ports
	localparam int NUM_IN_COSTS = 4;
	localparam int NCOST_W      = 3;

	// operation carried with each input transfer
	typedef enum logic [1:0] {
		MODE_PUSH  = 2'd0,
		MODE_POP   = 2'd1,
		MODE_PEEK  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	// result status
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// per-cycle commands broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} cell_ctrl_t;

endpackage

[rtl/lfpq_cell.sv]
// ----------------------------------------------------------------------------
// lfpq_cell
// One slot of the arrival-ordered chain. Holds an entry, loads a pushed entry
// when it is the first free slot, takes its right neighbor's entry on a
// removal at or below it, and passes a running minimum token to its right
// neighbor every cycle.
// ----------------------------------------------------------------------------
module lfpq_cell #(
	parameter int IDX       = 0,
	parameter int IDX_W     = 6,
	parameter int KEY_W     = 64,
	parameter int ID_BITS   = lfpq_pkg::ID_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lfpq_pkg::cell_ctrl_t   ctrl,
	input  logic [KEY_W-1:0]       key_mask,
	input  logic [IDX_W-1:0]       rm_idx,
	input  logic [KEY_W-1:0]       push_key,
	input  logic [ID_BITS-1:0]     push_id,
	// left neighbor occupancy
	input  logic                   prev_valid,
	// right neighbor entry
	input  logic                   next_valid,
	input  logic [KEY_W-1:0]       next_key,
	input  logic [ID_BITS-1:0]     next_id,
	// minimum token from the left
	input  logic                   tok_in_valid,
	input  logic [KEY_W-1:0]       tok_in_key,
	input  logic [ID_BITS-1:0]     tok_in_id,
	input  logic [IDX_W-1:0]       tok_in_idx,
	// own entry
	output logic                   valid,
	output logic [KEY_W-1:0]       key,
	output logic [ID_BITS-1:0]     id,
	// minimum token to the right
	output logic                   tok_valid,
	output logic [KEY_W-1:0]       tok_key,
	output logic [ID_BITS-1:0]     tok_id,
	output logic [IDX_W-1:0]       tok_idx
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic               valid_q;
	logic [KEY_W-1:0]   key_q;
	logic [ID_BITS-1:0] id_q;
	logic               tok_valid_q;
	logic [KEY_W-1:0]   tok_key_q;
	logic [ID_BITS-1:0] tok_id_q;
	logic [IDX_W-1:0]   tok_idx_q;
	logic               own_wins;
	logic               shift_in;
	logic               load_push;

	// strict less keeps the older entry on equal keys
	assign own_wins = valid_q &&
		(!tok_in_valid || ((key_q & key_mask) < (tok_in_key & key_mask)));

	assign shift_in  = ctrl.pop && (rm_idx <= MY_IDX);
	assign load_push = ctrl.push && !valid_q && prev_valid;

	// entry slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (shift_in) begin
			valid_q <= next_valid;
		end else if (load_push) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_in) begin
			key_q <= next_key;
			id_q  <= next_id;
		end else if (load_push) begin
			key_q <= push_key;
			id_q  <= push_id;
		end
	end

	// running minimum wave
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in_valid || valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (own_wins) begin
			tok_key_q <= key_q;
			tok_id_q  <= id_q;
			tok_idx_q <= MY_IDX;
		end else begin
			tok_key_q <= tok_in_key;
			tok_id_q  <= tok_in_id;
			tok_idx_q <= tok_in_idx;
		end
	end

	assign valid     = valid_q;
	assign key       = key_q;
	assign id        = id_q;
	assign tok_valid = tok_valid_q;
	assign tok_key   = tok_key_q;
	assign tok_id    = tok_id_q;
	assign tok_idx   = tok_idx_q;

endmodule

[rtl/lexicographic_fifo_tiebreak_pqueue_top.sv]
// ----------------------------------------------------------------------------
// lexicographic_fifo_tiebreak_pqueue_top
// Bounded priority queue with lexicographic keys and arrival-order
// tie-breaking, built as a chain of entry cells.
// ----------------------------------------------------------------------------
// Each input transfer carries one operation in s_tuser (push, pop, peek,
// clear) and gives exactly one result transfer, whose status sits in m_tuser.
// Push, clear, and pop or peek on an empty queue answer directly from idle;
// pop and peek on a non-empty queue scan: a running-minimum token crosses
// the CAPACITY cells one cell per cycle, then the result is written and,
// for a pop, the winner and every cell above it take their right neighbor's
// entry in one step. Entries are held in arrival order, so a change of the
// key length between operations reorders nothing and ties always leave
// oldest first. A new item is taken when idle and the result register is free.
// ----------------------------------------------------------------------------
`include "lexicographic_fifo_tiebreak_pqueue_top_macros.svh"

module lexicographic_fifo_tiebreak_pqueue_top #(
	parameter int CAPACITY  = lfpq_pkg::CAPACITY,
	parameter int MAX_COSTS = lfpq_pkg::MAX_COSTS,
	parameter int COST_BITS = lfpq_pkg::COST_BITS,
	parameter int ID_BITS   = lfpq_pkg::ID_BITS,
	localparam int NIC        = lfpq_pkg::NUM_IN_COSTS,
	localparam int IN_DATA_W  = NIC * COST_BITS + ID_BITS,
	localparam int IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8,
	localparam int OCC_W      = $clog2(CAPACITY + 1),
	localparam int OUT_DATA_W = ID_BITS + NIC * COST_BITS + OCC_W,
	localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration: key length
	input  logic                         cfg_we,
	input  logic [lfpq_pkg::NCOST_W-1:0] cfg_wdata,
	// input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// cost0, cost1, cost2, cost3, sid
	input  logic [IN_TDATA_W-1:0]        s_tdata,
	// mode
	input  logic [1:0]                   s_tuser,
	// result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// out_sid, out_cost0, out_cost1, out_cost2, out_cost3, occupancy
	output logic [OUT_TDATA_W-1:0]       m_tdata,
	// status
	output logic [1:0]                   m_tuser
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int KEY_W = MAX_COSTS * COST_BITS;
	localparam int LAST  = CAPACITY - 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                       state_q;
	lfpq_pkg::mode_t              op_q;
	logic [IDX_W-1:0]             scan_cnt_q;
	logic [OCC_W-1:0]             count_q;
	logic [lfpq_pkg::NCOST_W-1:0] key_len_q;
	logic                         m_tvalid_q;
	lfpq_pkg::status_t            res_status_q;
	logic [ID_BITS-1:0]           res_id_q;
	logic [COST_BITS-1:0]         res_cost_q [NIC];
	logic [OCC_W-1:0]             res_occ_q;

	logic [lfpq_pkg::NCOST_W-1:0] n_eff;
	logic [KEY_W-1:0]             key_mask;
	logic [COST_BITS-1:0]         in_cost [NIC];
	logic [ID_BITS-1:0]           in_id;
	lfpq_pkg::mode_t              in_mode;
	logic [KEY_W-1:0]             push_key;
	logic [COST_BITS-1:0]         done_cost [NIC];
	logic                         accept;
	logic                         out_free;
	logic                         full;
	logic                         res_load;
	lfpq_pkg::cell_ctrl_t         ctrl;

	logic [CAPACITY-1:0]          cell_valid;
	logic [KEY_W-1:0]             cell_key [CAPACITY];
	logic [ID_BITS-1:0]           cell_id  [CAPACITY];
	logic [CAPACITY-1:0]          tok_valid;
	logic [KEY_W-1:0]             tok_key [CAPACITY];
	logic [ID_BITS-1:0]           tok_id  [CAPACITY];
	logic [IDX_W-1:0]             tok_idx [CAPACITY];

	// key length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= lfpq_pkg::NCOST_W'(1);
		end else if (cfg_we) begin
			key_len_q <= cfg_wdata;
		end
	end

	// clamp key length into 1..MAX_COSTS
	always_comb begin
		if (key_len_q == '0) begin
			n_eff = lfpq_pkg::NCOST_W'(1);
		end else if (key_len_q > lfpq_pkg::NCOST_W'(MAX_COSTS)) begin
			n_eff = lfpq_pkg::NCOST_W'(MAX_COSTS);
		end else begin
			n_eff = key_len_q;
		end
	end

	// input unpacking
	always_comb begin
		for (int j = 0; j < NIC; j++) begin
			in_cost[j] = s_tdata[j*COST_BITS +: COST_BITS];
		end
	end
	assign in_id   = s_tdata[NIC*COST_BITS +: ID_BITS];
	assign in_mode = lfpq_pkg::mode_t'(s_tuser);

	// key layout: cost0 in the top bits, compare mask per component
	for (genvar c = 0; c < MAX_COSTS; c++) begin : g_key
		localparam int LO = (MAX_COSTS - 1 - c) * COST_BITS;
		if (c < NIC) begin : g_in
			assign push_key[LO +: COST_BITS] = in_cost[c];
		end else begin : g_zero
			assign push_key[LO +: COST_BITS] = '0;
		end
		assign key_mask[LO +: COST_BITS] =
			(lfpq_pkg::NCOST_W'(c) < n_eff) ? '1 : '0;
	end

	// returned costs, zero beyond the compared components
	for (genvar j = 0; j < NIC; j++) begin : g_out
		if (j < MAX_COSTS) begin : g_used
			assign done_cost[j] = (lfpq_pkg::NCOST_W'(j) < n_eff) ?
				tok_key[LAST][(MAX_COSTS-1-j)*COST_BITS +: COST_BITS] : '0;
		end else begin : g_unused
			assign done_cost[j] = '0;
		end
	end

	// handshake and cell commands
	assign out_free   = !m_tvalid_q || m_tready;
	assign s_tready   = (state_q == ST_IDLE) && out_free;
	assign accept     = s_tvalid && s_tready;
	assign full       = (count_q == OCC_W'(CAPACITY));
	assign ctrl.push  = accept && (in_mode == lfpq_pkg::MODE_PUSH) && !full;
	assign ctrl.clear = accept && (in_mode == lfpq_pkg::MODE_CLEAR);
	assign ctrl.pop   = (state_q == ST_DONE) && out_free &&
		(op_q == lfpq_pkg::MODE_POP);

	// a new result enters the result register in this cycle
	assign res_load = (accept && !(((in_mode == lfpq_pkg::MODE_POP) ||
		(in_mode == lfpq_pkg::MODE_PEEK)) && (count_q != '0))) ||
		((state_q == ST_DONE) && out_free);

	// chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic               prev_v;
		logic               next_v;
		logic [KEY_W-1:0]   next_k;
		logic [ID_BITS-1:0] next_i;
		logic               tin_v;
		logic [KEY_W-1:0]   tin_k;
		logic [ID_BITS-1:0] tin_i;
		logic [IDX_W-1:0]   tin_x;

		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
			assign tin_v  = 1'b0;
			assign tin_k  = '0;
			assign tin_i  = '0;
			assign tin_x  = '0;
		end else begin : g_body
			assign prev_v = cell_valid[i-1];
			assign tin_v  = tok_valid[i-1];
			assign tin_k  = tok_key[i-1];
			assign tin_i  = tok_id[i-1];
			assign tin_x  = tok_idx[i-1];
		end

		if (i == LAST) begin : g_tail
			assign next_v = 1'b0;
			assign next_k = '0;
			assign next_i = '0;
		end else begin : g_link
			assign next_v = cell_valid[i+1];
			assign next_k = cell_key[i+1];
			assign next_i = cell_id[i+1];
		end

		lfpq_cell #(
			.IDX     (i),
			.IDX_W   (IDX_W),
			.KEY_W   (KEY_W),
			.ID_BITS (ID_BITS)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.key_mask     (key_mask),
			.rm_idx       (tok_idx[LAST]),
			.push_key     (push_key),
			.push_id      (in_id),
			.prev_valid   (prev_v),
			.next_valid   (next_v),
			.next_key     (next_k),
			.next_id      (next_i),
			.tok_in_valid (tin_v),
			.tok_in_key   (tin_k),
			.tok_in_id    (tin_i),
			.tok_in_idx   (tin_x),
			.valid        (cell_valid[i]),
			.key          (cell_key[i]),
			.id           (cell_id[i]),
			.tok_valid    (tok_valid[i]),
			.tok_key      (tok_key[i]),
			.tok_id       (tok_id[i]),
			.tok_idx      (tok_idx[i])
		);
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= lfpq_pkg::MODE_PUSH;
			scan_cnt_q   <= '0;
			count_q      <= '0;
			m_tvalid_q   <= 1'b0;
			res_status_q <= lfpq_pkg::STATUS_OK;
			res_id_q     <= '0;
			res_occ_q    <= '0;
			for (int j = 0; j < NIC; j++) begin
				res_cost_q[j] <= '0;
			end
		end else begin
			if (m_tvalid_q && m_tready && !res_load) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_id_q <= '0;
						for (int j = 0; j < NIC; j++) begin
							res_cost_q[j] <= '0;
						end
						unique case (in_mode) inside
							lfpq_pkg::MODE_PUSH: begin
								m_tvalid_q <= 1'b1;
								if (full) begin
									res_status_q <= lfpq_pkg::STATUS_FULL;
									res_occ_q    <= count_q;
								end else begin
									res_status_q <= lfpq_pkg::STATUS_OK;
									res_occ_q    <= count_q + OCC_W'(1);
									count_q      <= count_q + OCC_W'(1);
								end
							end
							lfpq_pkg::MODE_POP, lfpq_pkg::MODE_PEEK: begin
								if (count_q == '0) begin
									m_tvalid_q   <= 1'b1;
									res_status_q <= lfpq_pkg::STATUS_EMPTY;
									res_occ_q    <= count_q;
								end else begin
									op_q       <= in_mode;
									scan_cnt_q <= '0;
									state_q    <= ST_SCAN;
								end
							end
							lfpq_pkg::MODE_CLEAR: begin
								m_tvalid_q   <= 1'b1;
								res_status_q <= lfpq_pkg::STATUS_OK;
								res_occ_q    <= '0;
								count_q      <= '0;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// let the token cross every cell
					scan_cnt_q <= scan_cnt_q + IDX_W'(1);
					if (scan_cnt_q == IDX_W'(LAST)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q   <= 1'b1;
						res_status_q <= lfpq_pkg::STATUS_OK;
						res_id_q     <= tok_id[LAST];
						for (int j = 0; j < NIC; j++) begin
							res_cost_q[j] <= done_cost[j];
						end
						if (op_q == lfpq_pkg::MODE_POP) begin
							count_q   <= count_q - OCC_W'(1);
							res_occ_q <= count_q - OCC_W'(1);
						end else begin
							res_occ_q <= count_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output packing
	always_comb begin
		m_tdata = '0;
		m_tdata[ID_BITS-1:0] = res_id_q;
		for (int j = 0; j < NIC; j++) begin
			m_tdata[ID_BITS + j*COST_BITS +: COST_BITS] = res_cost_q[j];
		end
		m_tdata[ID_BITS + NIC*COST_BITS +: OCC_W] = res_occ_q;
	end
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_status_q;

	// checks
	`LFPQ_ASSERT_SAME(a_count_bound, 1'b1, count_q <= OCC_W'(CAPACITY), "count above capacity")
	`LFPQ_ASSERT_SAME(a_slot_cnt, 1'b1, OCC_W'($countones(cell_valid)) == count_q, "slot count")
	`LFPQ_ASSERT_SAME(a_done_token, state_q == ST_DONE, tok_valid[LAST], "no minimum")
	`LFPQ_ASSERT_NEXT(a_pop_dec, ctrl.pop, count_q == $past(count_q) - OCC_W'(1), "no shrink")

endmodule
